// File: design/assert_macros.svh
// assertion macros for the rtl of the velocity limiter
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define DMVL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// expression must never be true out of reset
`define DMVL_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// File: design/dmvl_pkg.sv
// shared types and constants of the drive mode velocity limiter
// no dependencies; imported by drive_mode_velocity_limiter and the testbench files
`default_nettype none

package dmvl_pkg;

  // field widths of the items and the registers
  localparam int VALUE_W  = 16;
  localparam int MODE_W   = 2;
  localparam int CENTER_W = 11;
  localparam int RADIUS_W = 12;

  // register port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_MODE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_RADIUS = 2'd2;

  // drive mode codes: everything other than omni reshapes the command
  localparam logic [MODE_W-1:0] MODE_OMNI = 2'd0;

  typedef struct packed {
    logic [VALUE_W-1:0] vel_forward_in;
    logic [VALUE_W-1:0] vel_lateral_in;
    logic [VALUE_W-1:0] yaw_rate_in;
  } vel_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] vel_forward_out;
    logic [VALUE_W-1:0] vel_lateral_out;
    logic [VALUE_W-1:0] yaw_rate_out;
  } vel_res_t;

endpackage

`default_nettype wire

// File: design/drive_mode_velocity_limiter.sv
// Drive mode velocity limiter: reshapes a planar velocity command for the configured
// drive mode, limits yaw to the minimum turning radius and derives the lateral part
// from the rotation center offset. Fully pipelined: one item per cycle while no result
// is held in the skid stage. The depth is set by the restoring radius divider, which
// resolves one quotient bit per stage. Results leave through an output register with
// a skid stage, so in_ready_o drops only once a result has been held back there.
// Registers sit on an APB port at byte addresses 0 (drive_mode), 4 (center_x_offset)
// and 8 (min_turn_radius). Depends on dmvl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module drive_mode_velocity_limiter import dmvl_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // command channel
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire vel_cmd_t              in_data_i,
  // result channel
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      vel_res_t              out_data_o,
  // register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready
);

  localparam int VW     = VALUE_W;
  localparam int NUM_W  = VW + FRACTION_BITS;
  localparam int LIM_W  = VW + RADIUS_W;
  localparam int CMP_W  = (NUM_W > LIM_W) ? NUM_W : LIM_W;
  localparam int REM_W  = RADIUS_W + 1;
  localparam int MW     = VW + CENTER_W;
  localparam int XLIM   = 2 << FRACTION_BITS;
  localparam int STG_B  = 1;
  localparam int STG_D0 = 2;
  localparam int STG_DN = STG_D0 + VW;
  localparam int STG_E  = STG_DN + 1;
  localparam int STG_F  = STG_E + 1;
  localparam int STG_G  = STG_F + 1;
  localparam int NSTG   = STG_G + 1;

  localparam logic signed [MW:0] RND  = (MW+1)'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [MW:0] VMAX = (MW+1)'($signed({1'b0, {(VW-1){1'b1}}}));
  localparam logic signed [MW:0] VMIN = ~VMAX;

  typedef struct packed {
    logic          omni;
    logic [VW-1:0] v;
    logic [VW-1:0] lat;
    logic [VW-1:0] w;
    logic [VW-1:0] av;
    logic [VW-1:0] aw;
  } stg_a_t;

  typedef struct packed {
    logic             omni;
    logic [VW-1:0]    v;
    logic [VW-1:0]    lat;
    logic [VW-1:0]    w;
    logic [VW-1:0]    aw;
    logic [LIM_W-1:0] lim;
    logic [NUM_W-1:0] num;
  } stg_b_t;

  typedef struct packed {
    logic             omni;
    logic             clip;
    logic [VW-1:0]    v;
    logic [VW-1:0]    lat;
    logic [VW-1:0]    w;
    logic [VW-1:0]    aw;
    logic [REM_W-1:0] rem;
    logic [VW-1:0]    dq;
  } stg_d_t;

  typedef struct packed {
    logic          omni;
    logic [VW-1:0] v;
    logic [VW-1:0] lat;
    logic [VW-1:0] w;
  } stg_e_t;

  typedef struct packed {
    logic          omni;
    logic [VW-1:0] v;
    logic [VW-1:0] lat;
    logic [VW-1:0] w;
    logic [MW-1:0] prod;
  } stg_f_t;

  // ---------------------------------------------------------------- registers
  logic [MODE_W-1:0]          drive_mode_q;
  logic signed [CENTER_W-1:0] center_x_q;
  logic [RADIUS_W-1:0]        min_radius_q;
  logic                       wr_en;
  logic [REG_IDX_W-1:0]       reg_idx;
  logic signed [CENTER_W-1:0] x_clamp;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_mode_q <= '0;
      center_x_q   <= '0;
      min_radius_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DRIVE_MODE: drive_mode_q <= pwdata[MODE_W-1:0];
        REG_CENTER_X:   center_x_q   <= pwdata[CENTER_W-1:0];
        REG_MIN_RADIUS: min_radius_q <= pwdata[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DRIVE_MODE: prdata = APB_DATA_W'(drive_mode_q);
      REG_CENTER_X:   prdata = APB_DATA_W'($unsigned(center_x_q));
      REG_MIN_RADIUS: prdata = APB_DATA_W'(min_radius_q);
      default:        prdata = '0;
    endcase
  end

  // center offset limited to +-2.0
  always_comb begin
    if (int'(center_x_q) > XLIM) begin
      x_clamp = CENTER_W'(XLIM);
    end else if (int'(center_x_q) < -XLIM) begin
      x_clamp = CENTER_W'(-XLIM);
    end else begin
      x_clamp = center_x_q;
    end
  end

  // ---------------------------------------------------------------- pipeline
  logic            adv;
  logic [NSTG-1:0] vld_q;
  stg_a_t          a_d, a_q;
  stg_b_t          b_d, b_q;
  stg_d_t          d0_d;
  stg_d_t          d_q [VW+1];
  stg_e_t          e_d, e_q;
  stg_f_t          f_d, f_q;
  vel_res_t        g_d, g_q;
  logic            g_omni_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // stage a: magnitudes
  always_comb begin
    a_d.omni = (drive_mode_q == MODE_OMNI);
    a_d.v    = in_data_i.vel_forward_in;
    a_d.lat  = in_data_i.vel_lateral_in;
    a_d.w    = in_data_i.yaw_rate_in;
    a_d.av   = a_d.v[VW-1] ? (~a_d.v + 1'b1) : a_d.v;
    a_d.aw   = a_d.w[VW-1] ? (~a_d.w + 1'b1) : a_d.w;
  end

  // stage b: radius times yaw, scaled forward speed
  always_comb begin
    b_d.omni = a_q.omni;
    b_d.v    = a_q.v;
    b_d.lat  = a_q.lat;
    b_d.w    = a_q.w;
    b_d.aw   = a_q.aw;
    b_d.lim  = LIM_W'(min_radius_q) * LIM_W'(a_q.aw);
    b_d.num  = {a_q.av, {FRACTION_BITS{1'b0}}};
  end

  // divider entry: radius test; when it holds, num >> VW is below the radius
  always_comb begin
    d0_d.omni = b_q.omni;
    d0_d.clip = (b_q.w != '0) && (min_radius_q != '0)
                && (CMP_W'(b_q.num) < CMP_W'(b_q.lim));
    d0_d.v    = b_q.v;
    d0_d.lat  = b_q.lat;
    d0_d.w    = b_q.w;
    d0_d.aw   = b_q.aw;
    d0_d.rem  = REM_W'(b_q.num >> VW);
    d0_d.dq   = b_q.num[VW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q     <= a_d;
      b_q     <= b_d;
      d_q[0]  <= d0_d;
      e_q     <= e_d;
      f_q     <= f_d;
      g_q     <= g_d;
      g_omni_q <= f_q.omni;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < VW; k++) begin : g_div
    logic [REM_W:0]   trial;
    logic             fits;
    stg_d_t           nxt;

    always_comb begin
      trial    = {d_q[k].rem, d_q[k].dq[VW-1]};
      fits     = trial >= (REM_W+1)'(min_radius_q);
      nxt      = d_q[k];
      nxt.rem  = fits ? REM_W'(trial - (REM_W+1)'(min_radius_q)) : REM_W'(trial);
      nxt.dq   = {d_q[k].dq[VW-2:0], fits};
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d_q[k+1] <= nxt;
      end
    end
  end

  // stage e: limited yaw with its sign kept
  always_comb begin
    e_d.omni = d_q[VW].omni;
    e_d.v    = d_q[VW].v;
    e_d.lat  = d_q[VW].lat;
    if (d_q[VW].clip && !d_q[VW].omni) begin
      e_d.w = d_q[VW].w[VW-1] ? (~d_q[VW].dq + 1'b1) : d_q[VW].dq;
    end else begin
      e_d.w = d_q[VW].w;
    end
  end

  // stage f: yaw times center offset
  logic signed [MW-1:0] w_ext;
  logic signed [MW-1:0] x_ext;

  always_comb begin
    w_ext    = MW'($signed(e_q.w));
    x_ext    = MW'(x_clamp);
    f_d.omni = e_q.omni;
    f_d.v    = e_q.v;
    f_d.lat  = e_q.lat;
    f_d.w    = e_q.w;
    f_d.prod = w_ext * x_ext;
  end

  // stage g: negate, round half up, saturate
  logic signed [MW:0] lat_sum;
  logic signed [MW:0] lat_sh;
  logic [VW-1:0]      lat_sat;

  always_comb begin
    lat_sum = RND - (MW+1)'($signed(f_q.prod));
    lat_sh  = lat_sum >>> FRACTION_BITS;
    if (lat_sh > VMAX) begin
      lat_sat = VMAX[VW-1:0];
    end else if (lat_sh < VMIN) begin
      lat_sat = VMIN[VW-1:0];
    end else begin
      lat_sat = lat_sh[VW-1:0];
    end
    g_d.vel_forward_out = f_q.v;
    g_d.vel_lateral_out = f_q.omni ? f_q.lat : lat_sat;
    g_d.yaw_rate_out    = f_q.w;
  end

  // ---------------------------------------------------------------- output with skid
  logic     out_valid_q, skid_valid_q;
  vel_res_t out_q, skid_q;
  logic     pop, push;

  assign adv  = !skid_valid_q;
  assign pop  = out_valid_q & out_ready_i;
  assign push = adv & vld_q[STG_G];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= g_q;
      end else begin
        out_q <= g_q;
      end
    end
  end

  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- checks
  `DMVL_ASSERT_NEVER(a_skid_without_out, clk_i, rst_ni,
    skid_valid_q && !out_valid_q, "skid holds an item while output is empty")
  `DMVL_ASSERT(a_clip_below_yaw, clk_i, rst_ni,
    (vld_q[STG_DN] && d_q[VW].clip && !d_q[VW].omni) |-> (d_q[VW].dq < d_q[VW].aw),
    "limited yaw magnitude not below commanded yaw")
  `DMVL_ASSERT(a_zero_yaw_lateral, clk_i, rst_ni,
    (vld_q[STG_G] && !g_omni_q && (g_q.yaw_rate_out == '0)) |-> (g_q.vel_lateral_out == '0),
    "zero yaw gives nonzero lateral output")
  `DMVL_ASSERT(a_stall_freezes, clk_i, rst_ni,
    (skid_valid_q && vld_q[STG_B]) |=> vld_q[STG_B],
    "pipeline item dropped during stall")

endmodule

`default_nettype wire

// File: tb/sv/dmvl_command_checker.sv
// checker for the drive mode velocity limiter: watches the command, result and
// register ports, predicts each result and compares it field by field
// depends on dmvl_pkg
module dmvl_command_checker import dmvl_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  vel_cmd_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  vel_res_t              out_data_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output int unsigned           mismatches_o,
  output int unsigned           outstanding_o
);

  logic [MODE_W-1:0]   mode_q;
  logic [CENTER_W-1:0] center_q;
  logic [RADIUS_W-1:0] radius_q;
  vel_res_t            shaped_q[$];
  int unsigned         mismatch_cnt;

  // reshape one command for the current mode, radius and center offset
  function automatic vel_res_t shape_command(vel_cmd_t cmd);
    longint fwd, lat, yaw, yaw_lim, fwd_mag, yaw_mag, mag;
    longint ctr, ctr_lim, rad, prod, lat_res, top, bot;
    vel_res_t res;
    fwd = longint'($signed(cmd.vel_forward_in));
    lat = longint'($signed(cmd.vel_lateral_in));
    yaw = longint'($signed(cmd.yaw_rate_in));
    yaw_lim = yaw;
    if (mode_q == MODE_OMNI) begin
      lat_res = lat;
    end else begin
      ctr_lim = longint'(2) << FRACTION_BITS;
      ctr = longint'($signed(center_q));
      rad = longint'(radius_q);
      fwd_mag = (fwd < 0) ? -fwd : fwd;
      yaw_mag = (yaw < 0) ? -yaw : yaw;
      top = (longint'(1) << (VALUE_W - 1)) - 1;
      bot = -top - 1;
      if (ctr > ctr_lim) ctr = ctr_lim;
      if (ctr < -ctr_lim) ctr = -ctr_lim;
      // turning radius below the minimum: scale yaw down, keep its sign
      if (yaw != 0 && rad > 0 && (fwd_mag << FRACTION_BITS) < rad * yaw_mag) begin
        mag = (fwd_mag << FRACTION_BITS) / rad;
        yaw_lim = (yaw < 0) ? -mag : mag;
      end
      prod = -yaw_lim * ctr;
      // round half up, then saturate
      lat_res = (prod + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
      if (lat_res > top) lat_res = top;
      if (lat_res < bot) lat_res = bot;
    end
    res.vel_forward_out = cmd.vel_forward_in;
    res.vel_lateral_out = lat_res[VALUE_W-1:0];
    res.yaw_rate_out    = yaw_lim[VALUE_W-1:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] exp_val,
                             logic [VALUE_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_val), $signed(act_val));
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vel_res_t exp_res;
    if (!rst_ni) begin
      mode_q        <= '0;
      center_q      <= '0;
      radius_q      <= '0;
      shaped_q.delete();
      mismatch_cnt  = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_ADDR_W-1:2])
          REG_DRIVE_MODE: mode_q   <= pwdata_i[MODE_W-1:0];
          REG_CENTER_X:   center_q <= pwdata_i[CENTER_W-1:0];
          REG_MIN_RADIUS: radius_q <= pwdata_i[RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) shaped_q.push_back(shape_command(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (shaped_q.size() == 0) begin
          $error("result with no command pending");
          mismatch_cnt++;
        end else begin
          exp_res = shaped_q.pop_front();
          check_field("vel_forward_out", exp_res.vel_forward_out, out_data_i.vel_forward_out);
          check_field("vel_lateral_out", exp_res.vel_lateral_out, out_data_i.vel_lateral_out);
          check_field("yaw_rate_out", exp_res.yaw_rate_out, out_data_i.yaw_rate_out);
        end
      end
      mismatches_o  <= mismatch_cnt;
      outstanding_o <= shaped_q.size();
    end
  end

endmodule

// File: tb/sv/drive_mode_velocity_limiter_tb.sv
// top of the drive mode velocity limiter testbench: clock, reset, commands,
// register writes and the verdict; checking lives in dmvl_command_checker
// depends on dmvl_pkg, dmvl_command_checker and drive_mode_velocity_limiter
module drive_mode_velocity_limiter_tb import dmvl_pkg::*;;

  localparam int FRACTION_BITS = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 50;

  localparam logic [MODE_W-1:0]    MODE_ACKERMANN = 2'd1;
  localparam logic [MODE_W-1:0]    MODE_DIFF      = 2'd2;
  localparam logic [MODE_W-1:0]    MODE_SPARE     = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED     = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  vel_cmd_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  vel_res_t              out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;
  bit          calm;

  drive_mode_velocity_limiter #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  dmvl_command_checker #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // no progress on any port for too long ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random stall bursts until the calm tail
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  task automatic send_cmd(logic [VALUE_W-1:0] fwd, logic [VALUE_W-1:0] lat,
                          logic [VALUE_W-1:0] yaw);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 12);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i                <= 1'b1;
    in_data_i.vel_forward_in  <= fwd;
    in_data_i.vel_lateral_in  <= lat;
    in_data_i.yaw_rate_in     <= yaw;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait until every result is out
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [MODE_W-1:0] mode, logic [CENTER_W-1:0] center,
                           logic [RADIUS_W-1:0] radius);
    drain();
    write_reg(REG_DRIVE_MODE, APB_DATA_W'(mode));
    write_reg(REG_CENTER_X, APB_DATA_W'(center));
    write_reg(REG_MIN_RADIUS, APB_DATA_W'(radius));
  endtask

  // mostly full range, some small values, some extremes
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          3: v = 16'h0001;
          default: v = 16'hffff;
        endcase
      end
      1, 2: v = VALUE_W'($urandom_range(0, 2047) - 1024);
      default: v = VALUE_W'($urandom());
    endcase
    return v;
  endfunction

  initial begin
    logic [MODE_W-1:0]   mode;
    logic [CENTER_W-1:0] center;
    logic [RADIUS_W-1:0] radius;
    logic [VALUE_W-1:0]  yaw;
    calm         = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // omni after reset: everything passes
    send_cmd(16'h7fff, 16'h8000, 16'h7fff);
    send_cmd(16'h8000, 16'h7fff, 16'h8000);
    send_cmd(16'h0100, 16'hff00, 16'h0000);

    // radius 1.0, center 1.0
    configure(MODE_ACKERMANN, 11'd256, 12'd256);
    send_cmd(16'h0100, 16'h1234, 16'h0000);  // zero yaw drops lateral
    send_cmd(16'h7fff, 16'h7fff, 16'h8000);  // clipped just below full scale
    send_cmd(16'h8000, 16'h0000, 16'h7fff);
    send_cmd(16'h0100, 16'h0000, 16'h0200);
    send_cmd(16'h0000, 16'h0000, 16'h0005);  // standing still clips yaw to zero
    send_cmd(16'h0001, 16'h0000, 16'hffff);  // radius exactly at the limit

    // smallest center offset, no clipping: rounding ties
    configure(MODE_DIFF, 11'd1, 12'd0);
    send_cmd(16'h0000, 16'h0000, 16'hff80);
    send_cmd(16'h0000, 16'h0000, 16'h0080);
    send_cmd(16'h0000, 16'h0000, 16'hfe80);
    send_cmd(16'h0000, 16'h0000, 16'h0180);

    // spare mode code, offset clamped to +2.0: lateral saturates
    configure(MODE_SPARE, 11'h3ff, 12'd0);
    send_cmd(16'h0000, 16'h0000, 16'h8000);
    send_cmd(16'h0000, 16'h0000, 16'h7fff);

    // offset clamped to -2.0, largest radius
    configure(MODE_ACKERMANN, 11'h400, 12'hfff);
    send_cmd(16'h7fff, 16'h0000, 16'h7fff);
    send_cmd(16'h8000, 16'h5555, 16'h8000);
    drain();
    write_reg(REG_UNUSED, 32'hffff_ffff);  // must not touch any register
    send_cmd(16'h1234, 16'h0000, 16'h0100);

    for (int p = 0; p < PHASES; p++) begin
      mode = MODE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: center = 11'h400;
        1: center = 11'h3ff;
        default: center = CENTER_W'($urandom_range(0, 2047));
      endcase
      case ($urandom_range(0, 4))
        0: radius = 12'd0;
        1: radius = 12'hfff;
        2: radius = RADIUS_W'($urandom_range(1, 512));
        default: radius = RADIUS_W'($urandom_range(0, 4095));
      endcase
      configure(mode, center, radius);
      if (p == PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        yaw = ($urandom_range(0, 9) == 0) ? '0 : pick_value();
        send_cmd(pick_value(), pick_value(), yaw);
      end
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: drive_mode_velocity_limiter.f
+incdir+design
design/dmvl_pkg.sv
design/drive_mode_velocity_limiter.sv
tb/sv/dmvl_command_checker.sv
tb/sv/drive_mode_velocity_limiter_tb.sv
